// File: design/qfs_pkg.sv
// Fixed-point constants, types and rounding helpers for the fast slerp pipeline.
package qfs_pkg;

    typedef logic signed [31:0] fx_t;   // Q4.28
    typedef logic signed [34:0] wx_t;   // Q7.28, series differences
    typedef logic signed [63:0] wd_t;   // wide scratch
    typedef logic signed [66:0] pr_t;   // full product

    localparam int QF              = 28;
    localparam int COMP_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF   = 14;
    localparam int T_BITS          = 17;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);

    localparam wd_t ONE        = 64'sd268435456;
    localparam wd_t HALF       = 64'sd134217728;
    localparam wd_t C_1P09     = 64'sd292594647;
    localparam wd_t C_P4765    = 64'sd127919427;
    localparam wd_t C_P0903    = 64'sd24248338;
    localparam wd_t C_INV22680 = 64'sd11836;
    localparam wd_t C_INV630   = 64'sd426088;
    localparam wd_t C_INV30    = 64'sd8947849;
    localparam wd_t C_INV3     = 64'sd89478485;
    localparam wd_t C_1P5      = 64'sd402653184;
    localparam wx_t WIDE_LIM   = 35'sd4294967295;
    localparam wd_t I32_MAX    = 64'sd2147483647;
    localparam wd_t I32_MIN    = -64'sd2147483648;

    function automatic fx_t sat32(wd_t v);
        fx_t r;
        if (v > I32_MAX)
            r = fx_t'(I32_MAX);
        else if (v < I32_MIN)
            r = fx_t'(I32_MIN);
        else
            r = fx_t'(v);
        return r;
    endfunction

    // rounded arithmetic right shift, ties toward +inf
    function automatic wd_t rsh_n(wd_t v, int unsigned sh);
        wd_t r;
        if (sh == 0)
            r = v;
        else
            r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        return r;
    endfunction

    function automatic wd_t mulr(wx_t a, fx_t b);
        wx_t ac;
        pr_t p;
        if (a > WIDE_LIM)
            ac = WIDE_LIM;
        else if (a < -WIDE_LIM)
            ac = -WIDE_LIM;
        else
            ac = a;
        p = pr_t'(ac) * pr_t'(b);
        p = (p + (67'sd1 <<< (QF - 1))) >>> QF;
        return wd_t'(p);
    endfunction

    function automatic fx_t mulq(fx_t a, fx_t b);
        return sat32(mulr(wx_t'(a), b));
    endfunction

    function automatic fx_t mulqw(wx_t a, fx_t b);
        return sat32(mulr(a, b));
    endfunction

    // s - k, k a whole number, held in Q7.28
    function automatic wx_t sub_k(fx_t s, logic [4:0] k);
        return wx_t'(s) - (wx_t'({30'd0, k}) <<< QF);
    endfunction

endpackage

// File: design/quaternion_fast_slerp.sv
// Fast quaternion slerp (series approximation), fully pipelined top level.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------
//  request | a_x..a_w, b_x..b_w, fraction              | in_valid / in_ready
//  result  | out_x, out_y, out_z, out_w                | out_valid / out_ready
//
// One request per cycle sustained while in_ready is high; a result shows on out_valid
// after its request passes the input register, 23 compute stages and the output register.
// Depth is set by the chain of 21 dependent products (cosine, secant Newton step,
// two five-term series, length correction), at most one product per stage.
// Reset clears the valid bits, the output register flag and the skid flag only.
// A stalled result sits in the output register; one more lands in the skid
// register, after which in_ready drops and the whole pipe holds until it drains.
module quaternion_fast_slerp
    import qfs_pkg::*;
#(
    parameter int COMP_BITS = COMP_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COMP_BITS-1:0] a_x,
    input  logic signed [COMP_BITS-1:0] a_y,
    input  logic signed [COMP_BITS-1:0] a_z,
    input  logic signed [COMP_BITS-1:0] a_w,
    input  logic signed [COMP_BITS-1:0] b_x,
    input  logic signed [COMP_BITS-1:0] b_y,
    input  logic signed [COMP_BITS-1:0] b_z,
    input  logic signed [COMP_BITS-1:0] b_w,
    input  logic [T_BITS-1:0]           fraction,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COMP_BITS-1:0] out_x,
    output logic signed [COMP_BITS-1:0] out_y,
    output logic signed [COMP_BITS-1:0] out_z,
    output logic signed [COMP_BITS-1:0] out_w
);

    localparam int NST = 23;
    // shift between component format and Q4.28, one of the two is zero
    localparam int unsigned LSH = (FRAC_BITS <= QF) ? QF - FRAC_BITS : 0;
    localparam int unsigned RSH = (FRAC_BITS >  QF) ? FRAC_BITS - QF : 0;
    localparam wd_t OUT_HI = (64'sd1 <<< (COMP_BITS - 1)) - 64'sd1;
    localparam wd_t OUT_LO = -OUT_HI - 64'sd1;

    typedef logic [COMP_BITS-1:0] raw_t;

    typedef struct packed {
        raw_t [3:0]      ra;
        raw_t [3:0]      rb;
        logic [T_BITS-1:0] t;
        logic            byp;    // pass an input straight through
        logic            selb;   // pass b rather than a
        logic            neg;
        fx_t             halfy;
        fx_t             f1;
        fx_t             f2a;
        fx_t             f2b;
        fx_t             u;
        fx_t             hs;
        fx_t             vers;
        fx_t             tmp;
        fx_t             s1;
        fx_t             s2;
        fx_t             r1;
        fx_t             r2;
        fx_t             al;
        fx_t             be;
        fx_t [3:0]       q;
        wd_t [3:0]       mp;
        wd_t [3:0]       mq;
    } stage_t;

    function automatic fx_t to_int(raw_t raw);
        wd_t s;
        s = wd_t'(signed'(raw));
        return sat32(rsh_n(s <<< LSH, RSH));
    endfunction

    function automatic raw_t to_out(fx_t v);
        wd_t r;
        r = rsh_n(wd_t'(v), LSH) <<< RSH;
        if (r > OUT_HI)
            r = OUT_HI;
        else if (r < OUT_LO)
            r = OUT_LO;
        return raw_t'(r);
    endfunction

    stage_t           pipe_reg [NST+1];
    stage_t           pipe_next [1:NST];
    stage_t           st0_next;
    logic [NST:0]     vld_reg;
    logic             en;

    raw_t [3:0]       out_reg, out_next, skid_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_full_reg, skid_full_next;
    logic             load_out, load_skid, from_skid;

    assign en       = !skid_full_reg;
    assign in_ready = !skid_full_reg;

    // stage 0: capture, clamp t, spot the pass-through cases
    always_comb
    begin
        logic [T_BITS-1:0] tc;
        logic              same;
        st0_next = pipe_reg[0];
        st0_next.ra = {raw_t'(a_w), raw_t'(a_z), raw_t'(a_y), raw_t'(a_x)};
        st0_next.rb = {raw_t'(b_w), raw_t'(b_z), raw_t'(b_y), raw_t'(b_x)};
        tc   = (fraction > T_ONE) ? T_ONE : fraction;
        same = (a_x == b_x) && (a_y == b_y) && (a_z == b_z) && (a_w == b_w);
        st0_next.t    = tc;
        st0_next.byp  = same || (tc == '0) || (tc == T_ONE);
        st0_next.selb = (tc == T_ONE) && !same;
    end

    // compute stages, at most one product deep each
    always_comb
    begin
        stage_t p;
        wd_t    c, f2b, u;
        for (int k = 1; k <= NST; k++)
        begin
            p = pipe_reg[k-1];
            c = '0;
            f2b = '0;
            u = '0;
            case (k)
                1:
                begin
                    for (int i = 0; i < 4; i++)
                        p.mp[i] = mulr(wx_t'(to_int(p.ra[i])), to_int(p.rb[i]));
                end
                2:
                begin
                    c = wd_t'(sat32(p.mp[0] + p.mp[1] + p.mp[2] + p.mp[3]));
                    p.neg   = c < 0;
                    p.halfy = sat32(ONE + (c < 0 ? -c : c));
                    // fold t about one half
                    f2b   = (wd_t'({47'd0, p.t}) <<< (QF - 16)) - HALF;
                    u     = (f2b >= 0) ? f2b : -f2b;
                    p.f2a = fx_t'(u - f2b);
                    p.f2b = fx_t'(f2b + u);
                    p.u   = fx_t'(u + u);
                    p.f1  = fx_t'(ONE - (u + u));
                end
                3:  p.tmp = sat32(C_P4765 - wd_t'(mulq(fx_t'(C_P0903), p.halfy)));
                4:  p.hs  = sat32(C_1P09 - wd_t'(mulq(p.tmp, p.halfy)));
                5:  p.tmp = mulq(p.halfy, p.hs);
                6:  p.tmp = sat32(C_1P5 - wd_t'(mulq(p.tmp, p.hs)));
                7:  p.hs  = mulq(p.hs, p.tmp);
                8:
                begin
                    p.vers = sat32(ONE - wd_t'(mulq(p.halfy, p.hs)));
                    p.s1   = mulq(p.f1, p.f1);
                    p.s2   = mulq(p.u, p.u);
                end
                9:
                begin
                    p.r1 = mulq(fx_t'(C_INV22680), p.vers);
                    p.r2 = p.r1;
                end
                10:
                begin
                    p.r1 = sat32(wd_t'(mulqw(sub_k(p.s1, 5'd16), p.r1)) - C_INV630);
                    p.r2 = sat32(wd_t'(mulqw(sub_k(p.s2, 5'd16), p.r2)) - C_INV630);
                end
                11:
                begin
                    p.r1 = mulqw(sub_k(p.s1, 5'd9), p.r1);
                    p.r2 = mulqw(sub_k(p.s2, 5'd9), p.r2);
                end
                12:
                begin
                    p.r1 = sat32(C_INV30 + wd_t'(mulq(p.r1, p.vers)));
                    p.r2 = sat32(C_INV30 + wd_t'(mulq(p.r2, p.vers)));
                end
                13:
                begin
                    p.r1 = mulqw(sub_k(p.s1, 5'd4), p.r1);
                    p.r2 = mulqw(sub_k(p.s2, 5'd4), p.r2);
                end
                14:
                begin
                    p.r1 = sat32(wd_t'(mulq(p.r1, p.vers)) - C_INV3);
                    p.r2 = sat32(wd_t'(mulq(p.r2, p.vers)) - C_INV3);
                end
                15:
                begin
                    p.r1 = mulqw(sub_k(p.s1, 5'd1), p.r1);
                    p.r2 = mulqw(sub_k(p.s2, 5'd1), p.r2);
                end
                16:
                begin
                    p.r1 = sat32(ONE + wd_t'(mulq(p.r1, p.vers)));
                    p.r2 = sat32(ONE + wd_t'(mulq(p.r2, p.vers)));
                end
                17:
                begin
                    p.tmp = mulq(p.r1, p.hs);
                    p.f2a = mulq(p.f2a, p.r2);
                    p.f2b = mulq(p.f2b, p.r2);
                end
                18:
                begin
                    p.f1 = mulq(p.f1, p.tmp);
                    p.al = sat32(wd_t'(p.f1) + wd_t'(p.f2a));
                    if (p.neg)
                        p.al = sat32(-wd_t'(p.al));
                    p.be = sat32(wd_t'(p.f1) + wd_t'(p.f2b));
                end
                19:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        p.mp[i] = mulr(wx_t'(p.al), to_int(p.ra[i]));
                        p.mq[i] = mulr(wx_t'(p.be), to_int(p.rb[i]));
                    end
                end
                20:
                begin
                    for (int i = 0; i < 4; i++)
                        p.q[i] = sat32(p.mp[i] + p.mq[i]);
                end
                21:
                begin
                    for (int i = 0; i < 4; i++)
                        p.mp[i] = mulr(wx_t'(p.q[i]), p.q[i]);
                end
                22:
                begin
                    // first-order length correction 1.5 - len/2
                    p.tmp = sat32(C_1P5 - wd_t'(mulq(fx_t'(HALF),
                                  sat32(p.mp[0] + p.mp[1] + p.mp[2] + p.mp[3]))));
                end
                23:
                begin
                    for (int i = 0; i < 4; i++)
                        p.q[i] = mulq(p.q[i], p.tmp);
                end
                default:
                begin
                    p = pipe_reg[k-1];
                end
            endcase
            pipe_next[k] = p;
        end
    end

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= st0_next;
            for (int k = 1; k <= NST; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-1:0], in_valid};
    end

    // output register with one skid entry
    always_comb
    begin
        stage_t f;
        f = pipe_reg[NST];
        for (int i = 0; i < 4; i++)
            out_next[i] = f.byp ? (f.selb ? f.rb[i] : f.ra[i]) : to_out(f.q[i]);
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out  = 1'b0;
        load_skid = 1'b0;
        from_skid = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                from_skid      = 1'b1;
                out_valid_next = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (vld_reg[NST])
        begin
            if (!out_valid_reg || out_ready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid      = 1'b1;
                skid_full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (from_skid)
            out_reg <= skid_reg;
        else if (load_out)
            out_reg <= out_next;
        if (load_skid)
            skid_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign out_w     = out_reg[3];

endmodule

// File: design/qfs_chk.sv
// Port-level checker for the fast slerp pipeline, bound to the top level.
module qfs_chk
    import qfs_pkg::*;
#(
    parameter int COMP_BITS = COMP_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [COMP_BITS-1:0] out_x,
    input logic [COMP_BITS-1:0] out_w
);

    // a result, once shown, stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_w))
        else $error("stalled result changed");

    // requests are refused only while a result is waiting
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request refused with no result pending");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("ready dropped without an output stall");

endmodule

bind quaternion_fast_slerp qfs_chk #(.COMP_BITS(COMP_BITS)) u_qfs_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_w     (out_w)
);

// File: sim/tb_top.sv
// Self-checking testbench for the fast quaternion slerp pipeline.
`timescale 1ns / 100ps

module tb_top;
    import qfs_pkg::*;

    localparam int CB = COMP_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int Q = 28;
    localparam longint ONE_Q = 64'sd1 <<< Q;
    localparam longint HALF_Q = 64'sd1 <<< (Q - 1);
    localparam longint WLIM = 64'sd4294967295;
    localparam logic [16:0] T_FULL = 17'd65536;

    // one request: a_x..a_w in c[0..3], b_x..b_w in c[4..7]
    typedef struct {
        logic signed [CB-1:0] c[8];
        logic [16:0]          t;
    } slerp_req_t;

    typedef struct {
        logic signed [CB-1:0] v[4];
    } quat_t;

    // directed row: request plus an optional hand-typed answer
    typedef struct {
        slerp_req_t req;
        bit         typed;
        quat_t      ans;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CB-1:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
    logic [16:0] fraction;
    logic out_valid;
    logic out_ready;
    logic signed [CB-1:0] out_x, out_y, out_z, out_w;

    quat_t  pending_q[$];   // results still owed by the pipe
    int     mismatches;
    int     phase;          // 0 free run, 1 sender idle, 2 receiver stalls, 3 both
    int     hold_left;      // long receiver hold-off, counted down by the receiver
    bit     drive_done;

    quaternion_fast_slerp i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .fraction(fraction),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // fixed-point helpers, Q4.28 in 64-bit scratch
    // ---------------------------------------------------------------
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties upward
    function automatic longint rnd_shr(longint v, int sh);
        if (sh == 0)
            return v;
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // first operand may be a wide Q7.28 difference
    function automatic longint prod_r(longint a, longint b);
        longint ac;
        ac = a;
        if (ac > WLIM)
            ac = WLIM;
        if (ac < -WLIM)
            ac = -WLIM;
        return rnd_shr(ac * clip32(b), Q);
    endfunction

    function automatic longint prod_q(longint a, longint b);
        return clip32(prod_r(a, b));
    endfunction

    // five-term series for the blend coefficient
    function automatic longint coef_series(longint s, longint vers);
        longint r;
        r = prod_q(64'sd11836, vers);
        r = clip32(-64'sd426088 + prod_q(s - 16 * ONE_Q, r));
        r = clip32(64'sd8947849 + prod_q(prod_q(s - 9 * ONE_Q, r), vers));
        r = clip32(-64'sd89478485 + prod_q(prod_q(s - 4 * ONE_Q, r), vers));
        r = clip32(ONE_Q + prod_q(prod_q(s - ONE_Q, r), vers));
        return r;
    endfunction

    function automatic logic signed [CB-1:0] to_comp(longint v);
        longint r;
        r = rnd_shr(v, Q - FB);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return CB'(r);
    endfunction

    function automatic quat_t blend_quat(slerp_req_t rq);
        quat_t  res;
        longint a[4], b[4], qv[4];
        longint cosv, halfy, u, f1, f2a, f2b, hs, vers, r1, r2, al, be, len, fc;
        logic [16:0] t;
        bit     neg, same;
        same = 1'b1;
        for (int i = 0; i < 4; i++)
            if (rq.c[i] != rq.c[i + 4])
                same = 1'b0;
        t = (rq.t > T_FULL) ? T_FULL : rq.t;
        if (t == 0 || same || t == T_FULL)
        begin
            for (int i = 0; i < 4; i++)
                res.v[i] = (t == T_FULL && !same) ? rq.c[i + 4] : rq.c[i];
            return res;
        end
        for (int i = 0; i < 4; i++)
        begin
            a[i] = longint'(rq.c[i]) <<< (Q - FB);
            b[i] = longint'(rq.c[i + 4]) <<< (Q - FB);
        end
        cosv = 0;
        for (int i = 0; i < 4; i++)
            cosv += prod_r(a[i], b[i]);
        cosv = clip32(cosv);
        neg = cosv < 0;
        halfy = clip32(ONE_Q + (neg ? -cosv : cosv));
        // fold t about one half
        f2b = (longint'(t) <<< (Q - 16)) - HALF_Q;
        u = (f2b >= 0) ? f2b : -f2b;
        f2a = u - f2b;
        f2b += u;
        u += u;
        f1 = ONE_Q - u;
        // half-angle secant: seed then one Newton step
        hs = clip32(64'sd292594647
                    - prod_q(clip32(64'sd127919427 - prod_q(64'sd24248338, halfy)), halfy));
        hs = prod_q(hs, clip32(64'sd402653184 - prod_q(prod_q(halfy, hs), hs)));
        vers = clip32(ONE_Q - prod_q(halfy, hs));
        r1 = coef_series(prod_q(f1, f1), vers);
        r2 = coef_series(prod_q(u, u), vers);
        f1 = prod_q(f1, prod_q(r1, hs));
        f2a = prod_q(f2a, r2);
        f2b = prod_q(f2b, r2);
        al = clip32(f1 + f2a);
        if (neg)
            al = clip32(-al);
        be = clip32(f1 + f2b);
        len = 0;
        for (int i = 0; i < 4; i++)
        begin
            qv[i] = clip32(prod_r(al, a[i]) + prod_r(be, b[i]));
            len += prod_r(qv[i], qv[i]);
        end
        len = clip32(len);
        fc = clip32(64'sd402653184 - prod_q(HALF_Q, len));
        for (int i = 0; i < 4; i++)
            res.v[i] = to_comp(prod_q(qv[i], fc));
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    task automatic send_req(slerp_req_t rq, bit has_ans, quat_t ans);
        bit idle_on;
        idle_on = (phase == 1 || phase == 3);
        while (idle_on && $urandom_range(99) < ((phase == 1) ? 76 : 12))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a_x <= rq.c[0]; a_y <= rq.c[1]; a_z <= rq.c[2]; a_w <= rq.c[3];
        b_x <= rq.c[4]; b_y <= rq.c[5]; b_z <= rq.c[6]; b_w <= rq.c[7];
        fraction <= rq.t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        pending_q.push_back(has_ans ? ans : blend_quat(rq));
    endtask

    function automatic logic signed [CB-1:0] rnd_comp(bit full);
        if (full)
            return CB'($urandom);
        return CB'($urandom_range(32768) - 16384);
    endfunction

    function automatic slerp_req_t rnd_req();
        slerp_req_t rq;
        int pick;
        pick = $urandom_range(99);
        for (int i = 0; i < 8; i++)
            rq.c[i] = rnd_comp(pick < 20);
        // near-equal and near-opposite pairs exercise the secant end points
        if (pick >= 20 && pick < 45)
            for (int i = 0; i < 4; i++)
                rq.c[i + 4] = rq.c[i] + CB'($urandom_range(64) - 32);
        else if (pick >= 45 && pick < 55)
            for (int i = 0; i < 4; i++)
                rq.c[i + 4] = -rq.c[i];
        else if (pick >= 55 && pick < 60)
            for (int i = 0; i < 4; i++)
                rq.c[i + 4] = rq.c[i];
        pick = $urandom_range(99);
        if (pick < 4)
            rq.t = 17'd0;
        else if (pick < 8)
            rq.t = T_FULL;
        else if (pick < 12)
            rq.t = 17'($urandom_range(131071, 65537));
        else
            rq.t = 17'($urandom_range(65535, 1));
        return rq;
    endfunction

    function automatic row_t mk_row(int ax, int ay, int az, int aw,
                                    int bx, int by, int bz, int bw,
                                    int t, bit typed, int ox, int oy, int oz, int ow);
        row_t r;
        r.req.c[0] = CB'(ax); r.req.c[1] = CB'(ay); r.req.c[2] = CB'(az); r.req.c[3] = CB'(aw);
        r.req.c[4] = CB'(bx); r.req.c[5] = CB'(by); r.req.c[6] = CB'(bz); r.req.c[7] = CB'(bw);
        r.req.t = 17'(t);
        r.typed = typed;
        r.ans.v[0] = CB'(ox); r.ans.v[1] = CB'(oy); r.ans.v[2] = CB'(oz); r.ans.v[3] = CB'(ow);
        return r;
    endfunction

    row_t directed[$];

    initial
    begin
        quat_t none;
        in_valid = 1'b0;
        {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
        fraction = '0;
        phase = 0;
        hold_left = 0;
        drive_done = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // t = 0 gives a, t = 1 (or above) gives b, equal inputs give a
        directed.push_back(mk_row(32767, -32768, 1, -1, -32768, 32767, 0, 5, 0,
                                  1, 32767, -32768, 1, -1));
        directed.push_back(mk_row(32767, -32768, 1, -1, -32768, 32767, 0, 5, 65536,
                                  1, -32768, 32767, 0, 5));
        directed.push_back(mk_row(100, 200, 300, 400, -1, -2, -3, -4, 131071,
                                  1, -1, -2, -3, -4));
        directed.push_back(mk_row(100, 200, 300, 400, -1, -2, -3, -4, 65537,
                                  1, -1, -2, -3, -4));
        directed.push_back(mk_row(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 32768,
                                  1, -32768, -32768, -32768, -32768));
        directed.push_back(mk_row(0, 0, 0, 16384, 0, 0, 0, 16384, 12345,
                                  1, 0, 0, 0, 16384));
        // predicted rows: identity to axis, short and long arc, t extremes
        directed.push_back(mk_row(0, 0, 0, 16384, 16384, 0, 0, 0, 32768, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(0, 0, 0, 16384, 0, 0, 0, -16384, 32768, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(11585, 0, 0, 11585, -11585, 0, 0, -11585, 1,
                                  0, 0, 0, 0, 0));
        directed.push_back(mk_row(0, 16384, 0, 0, 0, 0, 16384, 0, 65535, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(0, 16384, 0, 0, 0, 0, 16384, 0, 1, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                                  40000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32766,
                                  20000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(8192, -8192, 8192, -8192, 8192, 8192, -8192, -8192,
                                  49152, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
        foreach (directed[k])
            send_req(directed[k].req, directed[k].typed, directed[k].ans);

        // long receiver hold-off at the start while requests keep coming, and the four phases in turn
        hold_left = 300;
        for (int p = 0; p < 4; p++)
        begin
            phase = p;
            repeat (484)
                send_req(rnd_req(), 1'b0, none);
        end
        in_valid <= 1'b0;
        drive_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // result side: check at the edge, then choose next ready
    // ---------------------------------------------------------------
    initial
    begin
        quat_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                    report_mismatch("results outstanding", 0, 1);
                else
                begin
                    want = pending_q.pop_front();
                    if (out_x !== want.v[0]) report_mismatch("out_x", out_x, want.v[0]);
                    if (out_y !== want.v[1]) report_mismatch("out_y", out_y, want.v[1]);
                    if (out_z !== want.v[2]) report_mismatch("out_z", out_z, want.v[2]);
                    if (out_w !== want.v[3]) report_mismatch("out_w", out_w, want.v[3]);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (phase == 2)
                out_ready <= ($urandom_range(99) >= 76);
            else if (phase == 3)
                out_ready <= ($urandom_range(99) >= 12);
            else
                out_ready <= 1'b1;
        end
    end

    // drain, settle, verdict
    initial
    begin
        wait (drive_done);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
